@@ hw/rtl/slcd_pkg.sv @@
// Package for the sprite list compaction DMA: sizes, request and result codes.
`default_nettype none
package slcd_pkg;

  localparam int unsigned Entries = 256;
  localparam int unsigned CntW    = $clog2(Entries + 1);
  localparam int unsigned SlotW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned NumWords = 8;
  localparam int unsigned NwW     = 4;

  typedef logic [WordW-1:0] word_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ENTRY = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    K_COPIED  = 3'd0,
    K_SKIPPED = 3'd1,
    K_FILLED  = 3'd2,
    K_DONE    = 3'd3,
    K_REFUSED = 3'd4,
    K_STARTED = 3'd5
  } kind_e;

  localparam word_t EnableMask = 16'h8000;
  localparam word_t IdMask     = 16'h00ff;

endpackage
`default_nettype wire

@@ hw/rtl/sprite_list_compaction_dma.sv @@
// A beat accepted into the input register moves on to the result register when that is empty or being taken.
// Throughput: one beat per cycle, sustained, as long as the output side takes results.
// Every request is handled by one pass of counter logic between the two registers.
// The result register is refilled in the cycle it is taken, so no bubble appears.
// Reset (rst_ni low, async) clears the frame counters and both valid flags.
`default_nettype none
module sprite_list_compaction_dma (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic [1:0]                  req_type_i,
  input  wire slcd_pkg::word_t             word0_i,
  input  wire slcd_pkg::word_t             word1_i,
  input  wire slcd_pkg::word_t             word2_i,
  input  wire slcd_pkg::word_t             word3_i,
  input  wire slcd_pkg::word_t             word4_i,
  input  wire slcd_pkg::word_t             word5_i,
  input  wire slcd_pkg::word_t             word6_i,
  input  wire slcd_pkg::word_t             word7_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [2:0]                  kind_o,
  output      logic [slcd_pkg::SlotW-1:0]  slot_o,
  output      logic [slcd_pkg::NwW-1:0]    words_written_o,
  output      slcd_pkg::word_t             out_word0_o,
  output      slcd_pkg::word_t             out_word1_o,
  output      slcd_pkg::word_t             out_word2_o,
  output      slcd_pkg::word_t             out_word3_o,
  output      slcd_pkg::word_t             out_word4_o,
  output      slcd_pkg::word_t             out_word5_o,
  output      slcd_pkg::word_t             out_word6_o,
  output      slcd_pkg::word_t             out_word7_o
);
  import slcd_pkg::*;

  localparam cnt_t EntriesCnt = CntW'(Entries);

  // input stage
  logic  in_vld_q;
  req_e  req_q;
  word_t wrd_q [NumWords];

  // result stage
  logic                 out_vld_q;
  kind_e                kind_q, kind_d;
  logic [SlotW-1:0]     slot_q, slot_d;
  logic [NwW-1:0]       nw_q, nw_d;
  word_t                ow_q [NumWords];
  word_t                ow_d [NumWords];

  // frame counters
  cnt_t seen_q, seen_d;
  cnt_t act_q, act_d;
  cnt_t fill_q, fill_d;

  logic           s1_fire;
  logic           in_fire;
  logic [CntW:0]  next_slot;
  logic           active;

  assign s1_fire    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q    <= req_e'(req_type_i);
      wrd_q[0] <= word0_i;
      wrd_q[1] <= word1_i;
      wrd_q[2] <= word2_i;
      wrd_q[3] <= word3_i;
      wrd_q[4] <= word4_i;
      wrd_q[5] <= word5_i;
      wrd_q[6] <= word6_i;
      wrd_q[7] <= word7_i;
    end
  end

  assign active    = ((wrd_q[0] & EnableMask) != '0) && ((wrd_q[0] & IdMask) != '0);
  assign next_slot = {1'b0, act_q} + {1'b0, fill_q};

  always_comb begin
    seen_d = seen_q;
    act_d  = act_q;
    fill_d = fill_q;
    kind_d = K_REFUSED;
    slot_d = '0;
    nw_d   = '0;
    for (int i = 0; i < NumWords; i++) begin
      ow_d[i] = '0;
    end
    case (req_q)
      REQ_START: begin
        seen_d = '0;
        act_d  = '0;
        fill_d = '0;
        kind_d = K_STARTED;
      end
      REQ_ENTRY: begin
        if (seen_q < EntriesCnt) begin
          seen_d = seen_q + 1'b1;
          if (active) begin
            kind_d = K_COPIED;
            slot_d = act_q[SlotW-1:0];
            nw_d   = NwW'(NumWords);
            ow_d   = wrd_q;
            act_d  = act_q + 1'b1;
          end else begin
            kind_d = K_SKIPPED;
          end
        end
      end
      REQ_FILL: begin
        // fills only once the whole frame is in
        if (seen_q >= EntriesCnt) begin
          if (next_slot >= (CntW+1)'(Entries)) begin
            kind_d = K_DONE;
          end else begin
            kind_d = K_FILLED;
            slot_d = next_slot[SlotW-1:0];
            nw_d   = NwW'(1);
            fill_d = fill_q + 1'b1;
          end
        end
      end
      default: begin
        kind_d = K_REFUSED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      seen_q    <= '0;
      act_q     <= '0;
      fill_q    <= '0;
    end else begin
      if (s1_fire) begin
        out_vld_q <= 1'b1;
        seen_q    <= seen_d;
        act_q     <= act_d;
        fill_q    <= fill_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      kind_q <= kind_d;
      slot_q <= slot_d;
      nw_q   <= nw_d;
      ow_q   <= ow_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = kind_q;
  assign slot_o          = slot_q;
  assign words_written_o = nw_q;
  assign out_word0_o     = ow_q[0];
  assign out_word1_o     = ow_q[1];
  assign out_word2_o     = ow_q[2];
  assign out_word3_o     = ow_q[3];
  assign out_word4_o     = ow_q[4];
  assign out_word5_o     = ow_q[5];
  assign out_word6_o     = ow_q[6];
  assign out_word7_o     = ow_q[7];

  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= EntriesCnt)
    else $error("entry count ran past the frame");

  a_act_le_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_q <= seen_q)
    else $error("more copies than entries");

  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot <= (CntW+1)'(Entries))
    else $error("copied plus filled slots exceed the table");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && req_q == REQ_START |=> seen_q == '0 && act_q == '0 && fill_q == '0)
    else $error("start did not clear counters");

  a_copy_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && kind_q == K_COPIED |-> nw_q == NwW'(NumWords))
    else $error("copy result without full word count");

endmodule
`default_nettype wire

@@ sim/sprite_list_compaction_dma_tb.sv @@
// Testbench for the sprite list compaction DMA: random frames checked against a local predictor.
`timescale 1ns / 1ps
module sprite_list_compaction_dma_tb;
  import slcd_pkg::*;

  typedef word_t [NumWords-1:0] words_t;

  typedef struct packed {
    logic [1:0] req;
    words_t     w;
  } dma_req_t;

  typedef struct packed {
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic [NwW-1:0]   nw;
    words_t           w;
  } dma_result_t;

  logic   clk_i = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   [1:0] in_req = REQ_START;
  words_t in_words = '0;
  logic   out_ready = 1'b0;

  logic             in_ready_o;
  logic             out_valid_o;
  logic [2:0]       kind_o;
  logic [SlotW-1:0] slot_o;
  logic [NwW-1:0]   words_written_o;
  word_t            out_w [NumWords];

  dma_req_t    pending_reqs[$];
  dma_result_t due_results[$];
  dma_req_t    cur_req;
  int          stim_total = 0;
  int          n_accepted = 0;
  int          errors = 0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          out_stall = 0;
  int          out_calm = 0;

  // frame state mirrored by the predictor
  cnt_t frame_seen = '0;
  cnt_t packed_cnt = '0;
  cnt_t zero_fills = '0;

  sprite_list_compaction_dma uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .req_type_i      (in_req),
    .word0_i         (in_words[0]),
    .word1_i         (in_words[1]),
    .word2_i         (in_words[2]),
    .word3_i         (in_words[3]),
    .word4_i         (in_words[4]),
    .word5_i         (in_words[5]),
    .word6_i         (in_words[6]),
    .word7_i         (in_words[7]),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .kind_o          (kind_o),
    .slot_o          (slot_o),
    .words_written_o (words_written_o),
    .out_word0_o     (out_w[0]),
    .out_word1_o     (out_w[1]),
    .out_word2_o     (out_w[2]),
    .out_word3_o     (out_w[3]),
    .out_word4_o     (out_w[4]),
    .out_word5_o     (out_w[5]),
    .out_word6_o     (out_w[6]),
    .out_word7_o     (out_w[7])
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic dma_result_t dma_outcome(dma_req_t r);
    dma_result_t res;
    cnt_t        next_slot;
    res = '0;
    res.kind = K_REFUSED;
    case (r.req)
      REQ_START: begin
        frame_seen = '0;
        packed_cnt = '0;
        zero_fills = '0;
        res.kind = K_STARTED;
      end
      REQ_ENTRY: begin
        if (frame_seen < Entries) begin
          frame_seen = frame_seen + 1'b1;
          if ((r.w[0] & EnableMask) != '0 && (r.w[0] & IdMask) != '0) begin
            res.kind = K_COPIED;
            res.slot = packed_cnt[SlotW-1:0];
            res.nw   = NwW'(NumWords);
            res.w    = r.w;
            packed_cnt = packed_cnt + 1'b1;
          end else begin
            res.kind = K_SKIPPED;
          end
        end
      end
      REQ_FILL: begin
        if (frame_seen >= Entries) begin
          next_slot = packed_cnt + zero_fills;
          if (next_slot >= Entries) begin
            res.kind = K_DONE;
          end else begin
            res.kind = K_FILLED;
            res.slot = next_slot[SlotW-1:0];
            res.nw   = NwW'(1);
            zero_fills = zero_fills + 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(10, 4);
    return $urandom_range(50, 20);
  endfunction

  function automatic words_t rand_words();
    words_t w;
    for (int i = 0; i < NumWords; i++) w[i] = word_t'($urandom());
    return w;
  endfunction

  function automatic word_t pick_word0(bit active);
    word_t w;
    w = word_t'($urandom());
    if (active) begin
      w |= EnableMask;
      if ((w & IdMask) == '0) w[7:0] = 8'($urandom_range(255, 1));
    end else begin
      case ($urandom_range(2))
        0:       w &= ~EnableMask;
        1:       w &= ~IdMask;
        default: w &= ~(EnableMask | IdMask);
      endcase
    end
    return w;
  endfunction

  task automatic queue_req(logic [1:0] req, words_t w);
    dma_req_t r;
    r.req = req;
    r.w   = w;
    pending_reqs.push_back(r);
  endtask

  // start, the entries, overrun entries, fills through done; a cut below Entries ends the frame after cut entries
  task automatic add_frame(int active_pct, int cut);
    int     n_active;
    bit     act;
    words_t w;
    n_active = 0;
    queue_req(REQ_START, rand_words());
    for (int i = 0; i < Entries; i++) begin
      if (cut > 0 && i == cut) return;
      if ($urandom_range(24) == 0)
        queue_req($urandom_range(1) ? REQ_FILL : REQ_BAD, rand_words());
      act = ($urandom_range(99) < active_pct);
      w = rand_words();
      w[0] = pick_word0(act);
      n_active += act;
      queue_req(REQ_ENTRY, w);
    end
    repeat ($urandom_range(3, 1)) queue_req(REQ_ENTRY, rand_words());
    for (int i = n_active; i < Entries + 3; i++) begin
      if ($urandom_range(24) == 0) queue_req(REQ_BAD, rand_words());
      queue_req(REQ_FILL, rand_words());
    end
  endtask

  task automatic check_result(dma_result_t got);
    dma_result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: result with nothing expected, kind %0d slot %0d", $time, got.kind,
               got.slot);
      errors++;
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind) begin
      $display("%0t: kind mismatch, expected %0d, got %0d", $time, want.kind, got.kind);
      errors++;
    end
    if (got.slot !== want.slot) begin
      $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, got.slot);
      errors++;
    end
    if (got.nw !== want.nw) begin
      $display("%0t: words_written mismatch, expected %0d, got %0d", $time, want.nw, got.nw);
      errors++;
    end
    for (int i = 0; i < NumWords; i++) begin
      if (got.w[i] !== want.w[i]) begin
        $display("%0t: out_word%0d mismatch, expected %h, got %h", $time, i, want.w[i],
                 got.w[i]);
        errors++;
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        due_results.push_back(dma_outcome(cur_req));
        n_accepted++;
      end
      if (!(in_valid && !in_ready_o)) begin
        if (in_calm > 0) in_calm--;
        else if ($urandom_range(199) == 0) in_calm = $urandom_range(150, 40);
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          in_req   <= cur_req.req;
          in_words <= cur_req.w;
          in_valid <= 1'b1;
          in_gap = (in_calm > 0) ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    dma_result_t got;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        got.kind = kind_e'(kind_o);
        got.slot = slot_o;
        got.nw   = words_written_o;
        for (int i = 0; i < NumWords; i++) got.w[i] = out_w[i];
        check_result(got);
      end
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(199) == 0) out_calm = $urandom_range(150, 40);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_calm == 0 && $urandom_range(2) == 0) out_stall = pick_gap();
      end
    end
  end

  initial begin
    words_t w;
    // directed: word0 corners, early fill, bad request, ignored payloads
    queue_req(REQ_START, '1);
    queue_req(REQ_FILL, '1);
    w = '1;                 w[0] = 16'h80ff; queue_req(REQ_ENTRY, w);
    w = '0;                 w[0] = 16'h8001; queue_req(REQ_ENTRY, w);
    w = {8{16'haaaa}};      w[0] = 16'hffff; queue_req(REQ_ENTRY, w);
    w = '1;                 w[0] = 16'h8000; queue_req(REQ_ENTRY, w);
    w = '1;                 w[0] = 16'h00ff; queue_req(REQ_ENTRY, w);
    w = '1;                 w[0] = 16'h0000; queue_req(REQ_ENTRY, w);
    w = '1;                 w[0] = 16'h7fff; queue_req(REQ_ENTRY, w);
    queue_req(REQ_BAD, '1);
    w = {8{16'h5555}};      w[0] = 16'h8080; queue_req(REQ_ENTRY, w);
    queue_req(REQ_FILL, '0);
    queue_req(REQ_START, '0);

    add_frame(100, 0);
    add_frame(0, 0);
    add_frame($urandom_range(90, 10), $urandom_range(200, 10));
    while (pending_reqs.size() < 1800) add_frame($urandom_range(100), 0);
    stim_total = pending_reqs.size();

    while (n_accepted < stim_total) @(posedge clk_i);
    while (due_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
